[design/sik_pkg.sv]
// Shared constants, types and the arctangent table for the SCARA inverse kinematics block.
package sik_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORD_LAT     = CORDIC_STEPS + 1;
    localparam int SQ_IN_W      = 58;
    localparam int SQ_STEPS     = SQ_IN_W / 2;
    localparam int ROOT_W       = SQ_STEPS;
    localparam int IN_W         = 34;
    localparam int CW           = 52;
    localparam int ANG_W        = 34;
    localparam int LEN_W        = 14;
    localparam int PRE_LAT      = 4;
    localparam int SIDE_LEN     = SQ_STEPS + CORD_LAT;
    localparam int LAT          = PRE_LAT + SQ_STEPS + CORD_LAT + 1;

    typedef enum logic [1:0] {
        CFG_UPPER_LINK = 2'd0,
        CFG_LOWER_LINK = 2'd1,
        CFG_COLUMN     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0]     x;
        logic signed [15:0]     y;
        logic signed [15:0]     z;
        logic signed [32:0]     num;
        logic signed [IN_W-1:0] c3x;
        logic                   unr;
    } side_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = ANG_W'(536870912);
            1:       v = ANG_W'(316933406);
            2:       v = ANG_W'(167458907);
            3:       v = ANG_W'(85004756);
            4:       v = ANG_W'(42667331);
            5:       v = ANG_W'(21354465);
            6:       v = ANG_W'(10679838);
            7:       v = ANG_W'(5340245);
            8:       v = ANG_W'(2670163);
            9:       v = ANG_W'(1335087);
            10:      v = ANG_W'(667544);
            11:      v = ANG_W'(333772);
            12:      v = ANG_W'(166886);
            13:      v = ANG_W'(83443);
            14:      v = ANG_W'(41722);
            15:      v = ANG_W'(20861);
            16:      v = ANG_W'(10430);
            17:      v = ANG_W'(5215);
            18:      v = ANG_W'(2608);
            19:      v = ANG_W'(1304);
            20:      v = ANG_W'(652);
            21:      v = ANG_W'(326);
            22:      v = ANG_W'(163);
            23:      v = ANG_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/sik_sqrt.sv]
// Pipelined restoring integer square root, one result bit per stage.
module sik_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [sik_pkg::SQ_IN_W-1:0]   rad,
    output logic [sik_pkg::ROOT_W-1:0]    root
);
    import sik_pkg::*;

    logic [SQ_IN_W-1:0] rem_reg [SQ_STEPS];
    logic [SQ_IN_W-1:0] res_reg [SQ_STEPS];
    logic [SQ_IN_W-1:0] rem_cur [SQ_STEPS];
    logic [SQ_IN_W-1:0] res_cur [SQ_STEPS];
    logic [SQ_IN_W-1:0] rem_next [SQ_STEPS];
    logic [SQ_IN_W-1:0] res_next [SQ_STEPS];

    assign rem_cur[0] = rad;
    assign res_cur[0] = '0;

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++) begin : g_stage
            localparam logic [SQ_IN_W-1:0] BIT_V = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * i);
            logic [SQ_IN_W-1:0] trial;
            if (i > 0) begin : g_link
                assign rem_cur[i] = rem_reg[i-1];
                assign res_cur[i] = res_reg[i-1];
            end
            assign trial = res_cur[i] + BIT_V;
            always_comb begin
                if (rem_cur[i] >= trial) begin
                    rem_next[i] = rem_cur[i] - trial;
                    res_next[i] = (res_cur[i] >> 1) + BIT_V;
                end else begin
                    rem_next[i] = rem_cur[i];
                    res_next[i] = res_cur[i] >> 1;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next[i];
                    res_reg[i] <= res_next[i];
                end
            end
        end
    endgenerate

    assign root = res_reg[SQ_STEPS-1][ROOT_W-1:0];

endmodule

[design/sik_cordic.sv]
// Pipelined CORDIC vectoring unit computing atan2 in units of pi/2^31.
module sik_cordic (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [sik_pkg::IN_W-1:0]    y_in,
    input  logic signed [sik_pkg::IN_W-1:0]    x_in,
    output logic signed [sik_pkg::ANG_W-1:0]   ang_out
);
    import sik_pkg::*;

    logic signed [CW-1:0]    cx_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]    cy_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] ca_reg [CORDIC_STEPS+1];
    logic                    zero_reg [CORDIC_STEPS+1];

    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [CW-1:0]    cx_next;
    logic signed [CW-1:0]    cy_next;
    logic signed [ANG_W-1:0] ca_next;

    assign xs = CW'(x_in) <<< 16;
    assign ys = CW'(y_in) <<< 16;

    always_comb begin
        cx_next = xs;
        cy_next = ys;
        ca_next = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                cx_next = ys;
                cy_next = -xs;
                ca_next = ANG_W'(1073741824);
            end else begin
                cx_next = -ys;
                cy_next = xs;
                ca_next = -ANG_W'(1073741824);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0]   <= cx_next;
            cy_reg[0]   <= cy_next;
            ca_reg[0]   <= ca_next;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
            localparam logic signed [ANG_W-1:0] TAB = atan_entry(i);
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            assign dx = cy_reg[i] >>> i;
            assign dy = cx_reg[i] >>> i;
            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (cy_reg[i] > 0) begin
                        cx_reg[i+1] <= cx_reg[i] + dx;
                        cy_reg[i+1] <= cy_reg[i] - dy;
                        ca_reg[i+1] <= ca_reg[i] + TAB;
                    end else begin
                        cx_reg[i+1] <= cx_reg[i] - dx;
                        cy_reg[i+1] <= cy_reg[i] + dy;
                        ca_reg[i+1] <= ca_reg[i] - TAB;
                    end
                end
            end
        end
    endgenerate

    assign ang_out = zero_reg[CORDIC_STEPS] ? '0 : ca_reg[CORDIC_STEPS];

endmodule

[design/scara_inverse_kinematics.sv]
// Pipeline: 4 front stages, 29 root stages, 17 CORDIC stages and the output register.
// Throughput: one transfer per cycle; a stalled output freezes every stage of the pipeline.
// Reset clears all valid bits and sets the link lengths to 4096 and the column height to 4915.
module scara_inverse_kinematics (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // pos_x, pos_y, pos_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // shoulder_angle, elbow_angle, slide_offset, pad
    output logic                          m_tuser,   // unreachable
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [sik_pkg::LEN_W-1:0]     cfg_wdata
);
    import sik_pkg::*;

    logic [LEN_W-1:0] l1_reg, l2_reg, l3_reg;
    logic [LAT-1:0]   vld_reg;
    logic             adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= LEN_W'(4096);
            l2_reg <= LEN_W'(4096);
            l3_reg <= LEN_W'(4915);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_UPPER_LINK: l1_reg <= cfg_wdata;
                CFG_LOWER_LINK: l2_reg <= cfg_wdata;
                CFG_COLUMN:     l3_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Stage 1: squares and link products.
    logic signed [15:0] x1_reg, y1_reg, z1_reg;
    logic [30:0]        xx1_reg, yy1_reg;
    logic [27:0]        l1sq1_reg, l2sq1_reg;
    logic [28:0]        den1_reg;
    logic signed [31:0] xx_full, yy_full;
    logic [27:0]        l12;

    assign xx_full = $signed(s_tdata[15:0]) * $signed(s_tdata[15:0]);
    assign yy_full = $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
    assign l12     = l1_reg * l2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg    <= s_tdata[15:0];
            y1_reg    <= s_tdata[31:16];
            z1_reg    <= s_tdata[47:32];
            xx1_reg   <= xx_full[30:0];
            yy1_reg   <= yy_full[30:0];
            l1sq1_reg <= l1_reg * l1_reg;
            l2sq1_reg <= l2_reg * l2_reg;
            den1_reg  <= {l12, 1'b0};
        end
    end

    // Stage 2: numerator of the elbow cosine.
    logic signed [15:0] x2_reg, y2_reg, z2_reg;
    logic signed [32:0] num2_reg;
    logic [28:0]        den2_reg;
    logic [27:0]        l1sq2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            num2_reg  <= $signed({2'b00, xx1_reg}) + $signed({2'b00, yy1_reg})
                         - $signed({5'b0, l1sq1_reg}) - $signed({5'b0, l2sq1_reg});
            den2_reg  <= den1_reg;
            l1sq2_reg <= l1sq1_reg;
        end
    end

    // Stage 3: reach test and factors of den^2 - num^2.
    logic signed [15:0]     x3_reg, y3_reg, z3_reg;
    logic signed [32:0]     num3_reg;
    logic signed [IN_W-1:0] c3x3_reg;
    logic                   unr3_reg;
    logic [28:0]            dm3_reg;
    logic [29:0]            dp3_reg;
    logic [32:0]            anum_full;
    logic                   unr_next;

    assign anum_full = num2_reg[32] ? 33'(-num2_reg) : 33'(num2_reg);
    assign unr_next  = (den2_reg == '0) || (anum_full > {4'b0, den2_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;
            num3_reg <= num2_reg;
            c3x3_reg <= $signed({5'b0, l1sq2_reg, 1'b0}) + $signed({num2_reg[32], num2_reg});
            unr3_reg <= unr_next;
            dm3_reg  <= unr_next ? '0 : den2_reg - anum_full[28:0];
            dp3_reg  <= unr_next ? '0 : {1'b0, den2_reg} + {1'b0, anum_full[28:0]};
        end
    end

    // Stage 4: radicand, then the delay line that keeps side data aligned.
    logic [SQ_IN_W-1:0] rad4_reg;
    logic [58:0]        prod_full;
    side_t              side_reg [SIDE_LEN+1];

    assign prod_full = dm3_reg * dp3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad4_reg        <= prod_full[SQ_IN_W-1:0];
            side_reg[0].x   <= x3_reg;
            side_reg[0].y   <= y3_reg;
            side_reg[0].z   <= z3_reg;
            side_reg[0].num <= num3_reg;
            side_reg[0].c3x <= c3x3_reg;
            side_reg[0].unr <= unr3_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SIDE_LEN; k++) begin : g_side
            always_ff @(posedge aclk) begin
                if (adv) begin
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    logic [ROOT_W-1:0] root;

    sik_sqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .rad  (rad4_reg),
        .root (root)
    );

    side_t                   sq_side;
    logic signed [IN_W-1:0]  s_ext;
    logic signed [ANG_W-1:0] ang_pos, ang_elb, ang_cor;

    assign sq_side = side_reg[SQ_STEPS];
    assign s_ext   = $signed({{(IN_W-ROOT_W){1'b0}}, root});

    sik_cordic u_cordic_pos (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (IN_W'(sq_side.y)),
        .x_in    (IN_W'(sq_side.x)),
        .ang_out (ang_pos)
    );

    sik_cordic u_cordic_elb (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (s_ext),
        .x_in    ($signed({sq_side.num[32], sq_side.num})),
        .ang_out (ang_elb)
    );

    sik_cordic u_cordic_cor (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (s_ext),
        .x_in    (sq_side.c3x),
        .ang_out (ang_cor)
    );

    // Final stage: rounding, clamping, slide offset and the unreachable case.
    side_t                   fin_side;
    logic signed [ANG_W-1:0] a_sh, sh_rnd, e_rnd;
    logic [14:0]             elbow_next;
    logic signed [16:0]      d3;
    logic [15:0]             slide_next;

    assign fin_side = side_reg[SIDE_LEN];
    assign a_sh     = ang_pos - ang_cor;
    assign sh_rnd   = (a_sh + ANG_W'(32768)) >>> 16;
    assign e_rnd    = (ang_elb + ANG_W'(32768)) >>> 16;
    assign d3       = $signed({fin_side.z[15], fin_side.z}) - $signed({3'b0, l3_reg});

    always_comb begin
        if (e_rnd < 0) begin
            elbow_next = '0;
        end else if (e_rnd > ANG_W'(32767)) begin
            elbow_next = 15'h7FFF;
        end else begin
            elbow_next = e_rnd[14:0];
        end
        if (d3[16] && !d3[15]) begin
            slide_next = 16'h8000;
        end else begin
            slide_next = d3[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (fin_side.unr) begin
                m_tdata <= '0;
                m_tuser <= 1'b1;
            end else begin
                m_tdata <= {1'b0, slide_next, elbow_next, sh_rnd[15:0]};
                m_tuser <= 1'b0;
            end
        end
    end

    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("unreachable result carries non-zero data");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("valid bits not cleared by reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[47])
        else $error("padding bit of result set");

endmodule

[test/testbench.sv]
// Self-checking testbench for the SCARA inverse kinematics pipeline.
module testbench;
    import sik_pkg::*;

    typedef struct packed {
        logic signed [15:0] shoulder;
        logic [14:0]        elbow;
        logic signed [15:0] slide;
        logic               unr;
    } joints_t;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    logic [47:0] pose_queue[$];
    joints_t     joints_due[$];
    longint      link1 = 4096, link2 = 4096, column = 4915;
    bit          hold_off = 1'b0;
    bit          no_gaps = 1'b0;
    int          errors = 0;
    int          poses_sent = 0;
    int          joints_seen = 0;
    int          unreachable_seen = 0;
    int          tx_gap = 0, rx_gap = 0, quiet = 0;

    longint arc_table[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81};

    scara_inverse_kinematics u_top (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint yy, longint xx);
        longint ang, t, dx, dy;
        ang = 0;
        if (xx == 0 && yy == 0) return 0;
        xx = xx * 65536;
        yy = yy * 65536;
        if (xx < 0) begin
            t = xx;
            if (yy >= 0) begin
                xx = yy; yy = -t; ang = 1073741824;
            end else begin
                xx = -yy; yy = t; ang = -1073741824;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = yy >>> i;
            dy = xx >>> i;
            if (yy > 0) begin
                xx += dx; yy -= dy; ang += arc_table[i];
            end else begin
                xx -= dx; yy += dy; ang -= arc_table[i];
            end
        end
        return ang;
    endfunction

    function automatic joints_t solve_joints(logic [47:0] pose);
        joints_t r;
        longint x, y, z, num, den, anum, s, elb, sh, e, d3;
        x = longint'($signed(pose[15:0]));
        y = longint'($signed(pose[31:16]));
        z = longint'($signed(pose[47:32]));
        num = x * x + y * y - link1 * link1 - link2 * link2;
        den = 2 * link1 * link2;
        anum = num < 0 ? -num : num;
        r = '0;
        if (den == 0 || anum > den) begin
            r.unr = 1'b1;
            return r;
        end
        s = longint'(int_root(longint'(den * den) - longint'(anum * anum)));
        elb = vector_angle(s, num);
        sh = vector_angle(y, x) - vector_angle(s, 2 * link1 * link1 + num);
        e = (elb + 32768) >>> 16;
        if (e < 0) e = 0;
        if (e > 32767) e = 32767;
        d3 = z - column;
        if (d3 < -32768) d3 = -32768;
        if (d3 > 32767) d3 = 32767;
        r.shoulder = 16'((sh + 32768) >>> 16);
        r.elbow = 15'(e);
        r.slide = 16'(d3);
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // Source side: one transfer per accepted pose, expectations logged at acceptance.
    always @(posedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                joints_due.push_back(solve_joints(s_tdata));
                poses_sent++;
                next_valid = 1'b0;
                tx_gap = pick_gap();
            end
            if (!next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (!hold_off && pose_queue.size() > 0) begin
                    s_tdata <= pose_queue.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Sink side: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        joints_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                joints_seen++;
                if (m_tuser) unreachable_seen++;
                if (joints_due.size() == 0) begin
                    report_mismatch("result transfers against poses sent", joints_seen,
                                    poses_sent);
                end else begin
                    want = joints_due.pop_front();
                    if (m_tdata[15:0] !== want.shoulder)
                        report_mismatch("shoulder_angle", $signed(m_tdata[15:0]), want.shoulder);
                    if (m_tdata[30:16] !== want.elbow)
                        report_mismatch("elbow_angle", m_tdata[30:16], want.elbow);
                    if (m_tdata[46:31] !== want.slide)
                        report_mismatch("slide_offset", $signed(m_tdata[46:31]), want.slide);
                    if (m_tuser !== want.unr)
                        report_mismatch("unreachable", m_tuser, want.unr);
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                rx_gap = pick_gap();
                m_tready <= 1'b1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d results outstanding", joints_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pose_queue.size() > 0 || s_tvalid || joints_due.size() > 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_index_t idx, longint val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= LEN_W'(val);
        case (idx)
            CFG_UPPER_LINK: link1 = val;
            CFG_LOWER_LINK: link2 = val;
            default:        column = val;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_pose(int x, int y, int z);
        pose_queue.push_back({16'(z), 16'(y), 16'(x)});
    endtask

    task automatic random_poses(int count);
        int lim, x, y;
        for (int i = 0; i < count; i++) begin
            lim = int'(link1 + link2);
            if (lim > 32767) lim = 32767;
            if ($urandom_range(0, 9) < 7) begin
                x = $urandom_range(0, 2 * lim) - lim;
                y = $urandom_range(0, 2 * lim) - lim;
            end else begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end
            add_pose(x, y, $urandom_range(0, 65535) - 32768);
            if (i == count / 2) begin
                while (pose_queue.size() > 0) @(posedge aclk);
                hold_off = 1'b1;
                while (s_tvalid || joints_due.size() > 0) @(posedge aclk);
                hold_off = 1'b0;
            end
        end
    endtask

    task automatic run_phase(longint l1, longint l2, longint col, int count);
        drain();
        set_reg(CFG_UPPER_LINK, l1);
        set_reg(CFG_LOWER_LINK, l2);
        set_reg(CFG_COLUMN, col);
        random_poses(count);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        add_pose(0, 0, 0);
        add_pose(32767, 32767, 32767);
        add_pose(-32768, -32768, -32768);
        add_pose(8192, 0, 4915);
        add_pose(0, 8192, 0);
        add_pose(-8192, 0, 100);
        add_pose(0, -8192, -100);
        add_pose(4096, 4096, 16383);
        add_pose(-4096, -4096, -16383);
        add_pose(-4096, 4096, 1);
        add_pose(4096, -4096, -1);
        add_pose(-8192, -1, 0);
        add_pose(1, 0, -32768);
        add_pose(5000, 3000, 32767);
        add_pose(-2000, 6500, 2000);
        add_pose(32767, 0, 0);
        drain();
        set_reg(CFG_COLUMN, 16383);
        add_pose(0, 0, -32768);
        add_pose(100, 200, -16385);
        add_pose(0, 0, 32767);
        drain();
        set_reg(CFG_UPPER_LINK, 0);
        add_pose(0, 0, 0);
        add_pose(1000, 1000, 5);
        run_phase(4096, 4096, 4915, 250);
        run_phase(1, 1, 0, 150);
        run_phase(16383, 16383, 16383, 250);
        run_phase(1, 16383, 0, 200);
        no_gaps = 1'b1;
        run_phase($urandom_range(1, 16383), $urandom_range(1, 16383),
                  $urandom_range(0, 16383), 200);
        no_gaps = 1'b0;
        run_phase($urandom_range(1, 16383), $urandom_range(1, 16383),
                  $urandom_range(0, 16383), 200);
        drain();
        $display("Sent %0d poses over nine register settings, including zero and full-scale links.",
                 poses_sent);
        $display("Checked %0d joint results, %0d of them unreachable.",
                 joints_seen, unreachable_seen);
        if (errors == 0 && joints_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[filelist.f]
design/sik_pkg.sv
design/sik_sqrt.sv
design/sik_cordic.sv
design/scara_inverse_kinematics.sv
test/testbench.sv
